[rtl/core/fpc_pkg.sv]
// Shared types and constants for the framed packet checker.
// Depends on nothing; used by every module in rtl/core.
package fpc_pkg;

   // Framing constants.
   localparam logic [7:0] SyncReset = 8'h99;
   localparam logic [7:0] MinLength = 8'd6;

   // Frame parsing phases.
   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_LENGTH  = 3'd1,
      PH_SENDER  = 3'd2,
      PH_MESSAGE = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CHECK1  = 3'd5,
      PH_CHECK2  = 3'd6
   } phase_type;

   // Result kinds.
   localparam logic KindPayload = 1'b0;
   localparam logic KindStatus  = 1'b1;

   // Frame status codes.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_START = 2'd1,
      ST_BAD_CHECK = 2'd2,
      ST_BAD_LEN   = 2'd3
   } status_type;

   // One result item as it travels to the output queue.
   typedef struct packed {
      logic       item_kind;
      logic [7:0] payload_value;
      logic [7:0] payload_index;
      status_type status;
      logic [7:0] source_id;
      logic [7:0] msg_code;
      logic [7:0] frame_length;
   } result_type;

endpackage

[rtl/core/fpc_step.sv]
// Frame parser state and the per-byte step that produces at most one result.
// Depends on fpc_pkg for the phase type, status codes and result struct.
module fpc_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  logic [7:0]            byte_data,
   input  logic [7:0]            sync_value,
   output logic                  result_valid,
   output fpc_pkg::result_type   result
);

   fpc_pkg::phase_type phase_ff, phase_in;
   logic [7:0] position_ff, position_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] sender_ff, sender_in;
   logic [7:0] message_ff, message_in;
   logic [7:0] sum1_ff, sum1_in;
   logic [7:0] sum2_ff, sum2_in;
   logic [7:0] check1_ff, check1_in;

   logic [7:0] acc1;
   logic [7:0] acc2;
   logic [7:0] next_position;
   logic [7:0] payload_count;

   // Running mod-256 Fletcher sums with this byte folded in.
   assign acc1          = sum1_ff + byte_data;
   assign acc2          = sum2_ff + acc1;
   assign next_position = position_ff + 8'd1;
   assign payload_count = length_ff - fpc_pkg::MinLength;

   // Next state.
   always_comb begin
      phase_in    = phase_ff;
      position_in = position_ff;
      length_in   = length_ff;
      sender_in   = sender_ff;
      message_in  = message_ff;
      sum1_in     = sum1_ff;
      sum2_in     = sum2_ff;
      check1_in   = check1_ff;
      if (byte_valid) begin
         unique case (phase_ff)
            fpc_pkg::PH_LENGTH: begin
               sum1_in   = acc1;
               sum2_in   = acc2;
               length_in = byte_data;
               phase_in  = (byte_data < fpc_pkg::MinLength) ? fpc_pkg::PH_HUNT
                                                            : fpc_pkg::PH_SENDER;
            end
            fpc_pkg::PH_SENDER: begin
               sum1_in   = acc1;
               sum2_in   = acc2;
               sender_in = byte_data;
               phase_in  = fpc_pkg::PH_MESSAGE;
            end
            fpc_pkg::PH_MESSAGE: begin
               sum1_in     = acc1;
               sum2_in     = acc2;
               message_in  = byte_data;
               position_in = '0;
               phase_in    = (length_ff == fpc_pkg::MinLength) ? fpc_pkg::PH_CHECK1
                                                               : fpc_pkg::PH_PAYLOAD;
            end
            fpc_pkg::PH_PAYLOAD: begin
               sum1_in     = acc1;
               sum2_in     = acc2;
               position_in = next_position;
               if (next_position >= payload_count) begin
                  phase_in = fpc_pkg::PH_CHECK1;
               end
            end
            fpc_pkg::PH_CHECK1: begin
               check1_in = byte_data;
               phase_in  = fpc_pkg::PH_CHECK2;
            end
            fpc_pkg::PH_CHECK2: begin
               phase_in = fpc_pkg::PH_HUNT;
            end
            default: begin
               phase_in = fpc_pkg::PH_HUNT;
               if (byte_data == sync_value) begin
                  sum1_in     = '0;
                  sum2_in     = '0;
                  length_in   = '0;
                  sender_in   = '0;
                  message_in  = '0;
                  position_in = '0;
                  check1_in   = '0;
                  phase_in    = fpc_pkg::PH_LENGTH;
               end
            end
         endcase
      end
   end

   // Result for this byte.
   always_comb begin
      result_valid         = 1'b0;
      result.item_kind     = fpc_pkg::KindStatus;
      result.payload_value = '0;
      result.payload_index = '0;
      result.status        = fpc_pkg::ST_OK;
      result.source_id     = sender_ff;
      result.msg_code      = message_ff;
      result.frame_length  = length_ff;
      unique case (phase_ff)
         fpc_pkg::PH_LENGTH: begin
            result_valid        = byte_valid && (byte_data < fpc_pkg::MinLength);
            result.status       = fpc_pkg::ST_BAD_LEN;
            result.frame_length = byte_data;
         end
         fpc_pkg::PH_PAYLOAD: begin
            result_valid         = byte_valid;
            result.item_kind     = fpc_pkg::KindPayload;
            result.payload_value = byte_data;
            result.payload_index = position_ff;
         end
         fpc_pkg::PH_CHECK2: begin
            result_valid  = byte_valid;
            result.status = (check1_ff == sum1_ff && byte_data == sum2_ff)
                            ? fpc_pkg::ST_OK : fpc_pkg::ST_BAD_CHECK;
         end
         fpc_pkg::PH_SENDER, fpc_pkg::PH_MESSAGE, fpc_pkg::PH_CHECK1: begin
            result_valid = 1'b0;
         end
         default: begin
            result_valid        = byte_valid && (byte_data != sync_value);
            result.status       = fpc_pkg::ST_BAD_START;
            result.source_id    = '0;
            result.msg_code     = '0;
            result.frame_length = '0;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= fpc_pkg::PH_HUNT;
         position_ff <= '0;
         length_ff   <= '0;
         sender_ff   <= '0;
         message_ff  <= '0;
         sum1_ff     <= '0;
         sum2_ff     <= '0;
         check1_ff   <= '0;
      end else begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         length_ff   <= length_in;
         sender_ff   <= sender_in;
         message_ff  <= message_in;
         sum1_ff     <= sum1_in;
         sum2_ff     <= sum2_in;
         check1_ff   <= check1_in;
      end
   end

endmodule

[rtl/core/fpc_rsp_queue.sv]
// Two-entry result queue between the parser step and the response channel.
// Depends on fpc_pkg for the result struct.
module fpc_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fpc_pkg::result_type push_data,
   output logic                has_room,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output fpc_pkg::result_type rsp_data
);

   fpc_pkg::result_type entry_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign has_room  = (count_ff != 2'd2);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   // Pointer and fill count updates.
   always_comb begin
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // A push into a full queue would overwrite an undelivered result.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> has_room)
      else $error("result pushed into a full queue");

   // The fill count never exceeds the two entries.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   // A push into an empty queue shows up at the output in the next cycle.
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      (push && !rsp_valid) |=> rsp_valid)
      else $error("pushed result not visible");

endmodule

[rtl/core/framed_packet_checker.sv]
// Top level of the framed packet checker: input register, parser step, queue.
// Depends on fpc_pkg, fpc_step and fpc_rsp_queue.
//
// Usage: bytes of the framed stream arrive one request at a time on the req_
// channel (valid/ready). Each frame is sync byte, length, sender id, message
// id, payload, two mod-256 Fletcher check bytes. Each payload byte leaves on the
// rsp_ channel as a payload item; each finished frame, each bad length and
// each stray byte while hunting leaves as a status item. Other bytes give no
// response. The user sets the sync byte through csr_write_enable/csr_write_data
// only while the block is idle (the block does not enforce this); it resets to 0x99.
// An accepted request waits in the input register; its response is then
// written into the result queue, from which it is offered on the rsp_ channel.
// Throughput: one request per cycle while the result queue has room; the parser
// step lies between the input register and the two-entry result queue.
// Reset (synchronous, active high) returns to hunting, clears the sums and
// held bytes, and empties both the input register and the queue.
// When the receiver stalls, the queue absorbs up to two responses; once it is
// full the input register holds and req_ready drops until a slot frees.
module framed_packet_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_item_kind,
   output logic [7:0] rsp_payload_value,
   output logic [7:0] rsp_payload_index,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_source_id,
   output logic [7:0] rsp_msg_code,
   output logic [7:0] rsp_frame_length
);

   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          s1_byte_ff;
   logic [7:0]          sync_ff;
   logic                advance;
   logic                has_room;
   logic                step_valid;
   fpc_pkg::result_type step_result;
   fpc_pkg::result_type rsp_data;

   // The held request moves through the step when the queue has a slot.
   assign advance     = s1_valid_ff && has_room;
   assign req_ready   = !s1_valid_ff || has_room;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_data_byte;
      end
   end

   // Sync byte register.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= fpc_pkg::SyncReset;
      end else if (csr_write_enable) begin
         sync_ff <= csr_write_data;
      end
   end

   fpc_step u_step (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (advance),
      .byte_data    (s1_byte_ff),
      .sync_value   (sync_ff),
      .result_valid (step_valid),
      .result       (step_result)
   );

   fpc_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_valid),
      .push_data (step_result),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Response fields.
   assign rsp_item_kind     = rsp_data.item_kind;
   assign rsp_payload_value = rsp_data.payload_value;
   assign rsp_payload_index = rsp_data.payload_index;
   assign rsp_status        = rsp_data.status;
   assign rsp_source_id     = rsp_data.source_id;
   assign rsp_msg_code      = rsp_data.msg_code;
   assign rsp_frame_length  = rsp_data.frame_length;

endmodule
